// ===== hdl/fwie_pkg.sv =====
package fwie_pkg;

   // Storage geometry.
   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Command codes carried by a request.
   localparam logic [2:0] CMD_PUSH  = 3'd0;
   localparam logic [2:0] CMD_POP   = 3'd1;
   localparam logic [2:0] CMD_READ  = 3'd2;
   localparam logic [2:0] CMD_ERASE = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;

   // Status codes returned with each response.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] value;
      logic [3:0]  index;
   } fwie_req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [31:0]      read_value;
      logic [31:0]      front_value;
      logic [31:0]      back_value;
      logic [CNT_W-1:0] count;
      logic             is_empty;
   } fwie_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;
      logic load;
   } fwie_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;
   } fwie_stat_type;

endpackage

// ===== hdl/fwie_ctrl.sv =====
module fwie_ctrl import fwie_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  fwie_stat_type stat,
   output fwie_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_FINISH = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands: a request executes on acceptance, the response
   // is assembled in S_FINISH once the output register is free.
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd.exec  = 1'b0;
      cmd.load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.exec  = req_valid;
            if (req_valid) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.load = !stat.out_busy;
            if (!stat.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/fwie_datapath.sv =====
module fwie_datapath import fwie_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  fwie_req_type  req,
   input  fwie_cmd_type  cmd,
   output fwie_stat_type stat,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output fwie_rsp_type  rsp
);

   logic [31:0]      entries_ff [DEPTH];
   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;
   logic [1:0]       status_ff;
   logic [1:0]       status_in;
   logic [31:0]      read_ff;
   logic [31:0]      read_in;
   fwie_rsp_type     rsp_ff;
   fwie_rsp_type     rsp_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   logic [CNT_W-1:0]  occ_last;
   logic [ADDR_W-1:0] rd_addr;
   logic [31:0]       rd_data;
   logic              idx_ok;
   logic              do_push;
   logic              do_shift;
   logic [ADDR_W-1:0] shift_pos;

   // One read port: the request index while executing, the back entry after.
   assign occ_last = occ_ff - CNT_W'(1);
   assign rd_addr  = cmd.exec ? ADDR_W'(req.index) : occ_last[ADDR_W-1:0];
   assign rd_data  = entries_ff[rd_addr];
   assign idx_ok   = ({1'b0, req.index} < occ_ff);

   // Decode the request into storage updates and a status code.
   always_comb begin
      occ_in    = occ_ff;
      status_in = status_ff;
      read_in   = read_ff;
      do_push   = 1'b0;
      do_shift  = 1'b0;
      shift_pos = '0;
      if (cmd.exec) begin
         status_in = ST_OK;
         read_in   = '0;
         case (req.command)
            CMD_PUSH: begin
               if (occ_ff == CNT_W'(DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  do_push = 1'b1;
                  occ_in  = occ_ff + CNT_W'(1);
               end
            end
            CMD_POP: begin
               if (occ_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  do_shift = 1'b1;
                  occ_in   = occ_last;
               end
            end
            CMD_READ: begin
               if (!idx_ok) begin
                  status_in = ST_RANGE;
               end else begin
                  read_in = rd_data;
               end
            end
            CMD_ERASE: begin
               if (!idx_ok) begin
                  status_in = ST_RANGE;
               end else begin
                  do_shift  = 1'b1;
                  shift_pos = ADDR_W'(req.index);
                  occ_in    = occ_last;
               end
            end
            CMD_CLEAR: begin
               occ_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Entry storage: append at the fill point, or close up from a position.
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (do_push && (occ_ff[ADDR_W-1:0] == ADDR_W'(i))) begin
            entries_ff[i] <= req.value;
         end else if (do_shift && (i < DEPTH - 1) && (ADDR_W'(i) >= shift_pos)) begin
            entries_ff[i] <= entries_ff[(i + 1) % DEPTH];
         end
      end
   end

   // Response assembly from the updated state.
   always_comb begin
      rsp_in.status      = status_ff;
      rsp_in.read_value  = read_ff;
      rsp_in.front_value = (occ_ff != '0) ? entries_ff[0] : '0;
      rsp_in.back_value  = (occ_ff != '0) ? rd_data : '0;
      rsp_in.count       = occ_ff;
      rsp_in.is_empty    = (occ_ff == '0);
   end

   assign stat.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid_in  = cmd.load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      read_ff   <= read_in;
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hdl/fifo_with_indexed_erase.sv =====
// A request executes on acceptance; its response is then assembled into the output register in S_FINISH.
// No new request is taken until S_FINISH ends; execution and response assembly share one read port.
// A held response does not block acceptance of the next request; it stalls only S_FINISH.
// Reset is synchronous and active high: it empties the store and drops any pending response.
// Entry contents are not cleared by reset.
module fifo_with_indexed_erase import fwie_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  fwie_req_type req,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output fwie_rsp_type rsp
);

   fwie_cmd_type  cmd;
   fwie_stat_type stat;

   // Sequencing of each request.
   fwie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage, occupancy and the response register.
   fwie_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

// ===== hdl/fwie_checker.sv =====
module fwie_checker import fwie_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input fwie_req_type req,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input fwie_rsp_type rsp
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled response changed");

   // One request at a time: the block stalls right after accepting one.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while one is in progress");

   // The empty flag agrees with the count and the end values.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.is_empty == (rsp.count == '0)) && (rsp.count <= CNT_W'(DEPTH)))
      else $error("empty flag disagrees with count");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.is_empty |-> (rsp.front_value == '0) && (rsp.back_value == '0))
      else $error("empty store reports nonzero front or back");

   // An ignored pop only happens on an empty store.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == ST_EMPTY) |-> rsp.is_empty)
      else $error("empty status on a non-empty store");

endmodule

bind fifo_with_indexed_erase fwie_checker u_fwie_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
